// ----- hw/rtl/cbt_pkg.sv -----
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the CBOR item boundary tracker.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int unsigned MaxNestingDefault = 64;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrBadChunk = 3'd1;
  localparam logic [2:0] ErrMismatch = 3'd2;
  localparam logic [2:0] ErrBadHead  = 3'd3;
  localparam logic [2:0] ErrTooDeep  = 3'd4;

  localparam logic [1:0] KindArr = 2'd1;
  localparam logic [1:0] KindMap = 2'd2;
  localparam logic [1:0] KindTag = 2'd3;

  // datapath command from controller
  typedef enum logic [2:0] {
    CmdNone,
    CmdDecode,
    CmdFinish,
    CmdFinishTop
  } cmd_e;

  // status from datapath to controller
  typedef struct packed {
    logic       need_finish;
  } stat_t;

endpackage

// ----- hw/rtl/cbt_stream_if.sv -----
// ----------------------------------------------------------------------------
// cbt_in_if / cbt_out_if
// Valid/ready channels of the tracker.
// ----------------------------------------------------------------------------
interface cbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cbt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_end;
  logic [2:0] error_code;
  logic [6:0] nesting_depth;
  modport source (output valid, output out_byte, output item_end, output error_code,
                  output nesting_depth, input ready);
  modport sink   (input valid, input out_byte, input item_end, input error_code,
                  input nesting_depth, output ready);
endinterface

// ----- hw/rtl/cbor_item_boundary_tracker_top.sv -----
// ----------------------------------------------------------------------------
// cbor_item_boundary_tracker_top
// Byte-serial CBOR item boundary tracker and well-formedness checker.
// ----------------------------------------------------------------------------
// Usage: bytes enter on in_if; each produces exactly one result on out_if,
// carrying the byte itself, an item_end flag, an error code and the nesting
// depth after that byte.
// Sequence: a byte is decoded, then one finish step follows when the byte
// completes a data item and one more for each nesting level that this
// closes (tags, full arrays and maps); the result is then set on out_if.
// A new byte is taken only after the finish walk over the stack, one step
// per cycle, is done.
// A result waits in an output register; the next byte is taken while it
// waits as long as out ready is high at the time of the hand-off.
// Reset clears the parser to expect the head of a new top-level item with
// an empty stack; stack entries need no clearing.
// When the receiver stalls, the result holds and no new byte is taken.
// ----------------------------------------------------------------------------
module cbor_item_boundary_tracker_top
  import cbt_pkg::*;
#(
  parameter int unsigned MaxNesting = MaxNestingDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  cbt_in_if.sink    in_if,
  cbt_out_if.source out_if
);

  cmd_e  cmd;
  stat_t stat;

  cbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_byte_i   (in_if.in_byte),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_byte_o  (out_if.out_byte),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cbt_datapath #(.MaxNesting(MaxNesting)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .byte_i  (in_if.in_byte),
    .stat_o  (stat),
    .err_o   (out_if.error_code),
    .end_o   (out_if.item_end),
    .depth_o (out_if.nesting_depth)
  );

endmodule

// ----- hw/rtl/cbt_datapath.sv -----
// ----------------------------------------------------------------------------
// cbt_datapath
// Head decoder, counters and nesting stack; one finish step per cycle.
// ----------------------------------------------------------------------------
module cbt_datapath
  import cbt_pkg::*;
#(
  parameter int unsigned MaxNesting = MaxNestingDefault,
  localparam int unsigned SpW = $clog2(MaxNesting + 1),
  localparam int unsigned IdxW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  logic [7:0] byte_i,
  output stat_t      stat_o,
  output logic [2:0] err_o,
  output logic       end_o,
  output logic [6:0] depth_o
);

  logic [1:0]  phase_q, phase_d;
  logic [63:0] arg_q, arg_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] pay_q, pay_d;
  logic        chunk_q, chunk_d;
  logic [2:0]  cmaj_q, cmaj_d;
  logic [7:0]  head_q, head_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [2:0]  err_q, err_d;
  logic        end_q, end_d;
  logic        fin_q, fin_d;

  // stack memory: kind {value, indef, kind[1:0]} and remaining count
  logic [3:0]  kind_mem [MaxNesting];
  logic [63:0] rem_mem [MaxNesting];

  logic [IdxW-1:0] top_idx;
  logic [3:0]  top_kind;
  logic [63:0] top_rem;
  logic        we;
  logic [IdxW-1:0] widx;
  logic [3:0]  wkind;
  logic [63:0] wrem;
  logic [IdxW-1:0] rd_idx;
  logic [3:0]  rd_kind_q;
  logic [63:0] rd_rem_q;

  assign top_idx  = IdxW'(sp_q - SpW'(1));
  assign top_kind = rd_kind_q;
  assign top_rem  = rd_rem_q;
  // top entry of the coming cycle
  assign rd_idx   = (sp_d == '0) ? '0 : IdxW'(sp_d - SpW'(1));

  always_ff @(posedge clk_i) begin
    if (we) begin
      kind_mem[widx] <= wkind;
      rem_mem[widx]  <= wrem;
    end
  end

  // registered read of the next top entry, this cycle's write forwarded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_kind_q <= '0;
      rd_rem_q  <= '0;
    end else if (we && widx == rd_idx) begin
      rd_kind_q <= wkind;
      rd_rem_q  <= wrem;
    end else begin
      rd_kind_q <= kind_mem[rd_idx];
      rd_rem_q  <= rem_mem[rd_idx];
    end
  end

  always_comb begin
    logic [2:0]  maj;
    logic [4:0]  ai;
    logic [63:0] a;
    logic        hd;
    logic [1:0]  push_k;
    logic [63:0] push_c;
    logic        push;
    logic        clr;
    maj = 3'd0; ai = 5'd0; a = '0; hd = 1'b0;
    push = 1'b0; push_k = KindArr; push_c = '0; clr = 1'b0;
    phase_d = phase_q; arg_d = arg_q; left_d = left_q; pay_d = pay_q;
    chunk_d = chunk_q; cmaj_d = cmaj_q; head_d = head_q; sp_d = sp_q;
    err_d = err_q; end_d = end_q; fin_d = 1'b0;
    we = 1'b0; widx = top_idx; wkind = top_kind; wrem = top_rem;
    unique case (cmd_i)
      CmdDecode: begin
        err_d = ErrNone; end_d = 1'b0;
        if (phase_q == 2'd1) begin
          arg_d = {arg_q[55:0], byte_i};
          left_d = left_q - 4'd1;
          if (left_q == 4'd1) begin
            phase_d = 2'd0; hd = 1'b1;
            maj = head_q[7:5]; ai = head_q[4:0]; a = arg_d;
          end
        end else if (phase_q == 2'd2) begin
          pay_d = pay_q - 64'd1;
          if (pay_q == 64'd1) begin
            phase_d = 2'd0;
            fin_d = !chunk_q;
          end
        end else begin
          maj = byte_i[7:5]; ai = byte_i[4:0];
          if (ai >= 5'd28 && ai <= 5'd30) begin
            err_d = ErrBadHead; clr = 1'b1;
          end else if (chunk_q && byte_i == 8'hFF) begin
            chunk_d = 1'b0; cmaj_d = 3'd0; fin_d = 1'b1;
          end else if (chunk_q && (maj != cmaj_q || ai == 5'd31)) begin
            err_d = ErrBadChunk; clr = 1'b1;
          end else if (!chunk_q && ai == 5'd31) begin
            case (maj)
              3'd2, 3'd3: begin chunk_d = 1'b1; cmaj_d = maj; end
              3'd4: begin push = 1'b1; push_k = KindArr; end
              3'd5: begin push = 1'b1; push_k = KindMap; end
              3'd7: begin
                if (sp_q == '0 || !top_kind[2] ||
                    (top_kind[1:0] == KindMap && top_kind[3])) begin
                  err_d = ErrMismatch; clr = 1'b1;
                end else begin
                  sp_d = sp_q - SpW'(1); fin_d = 1'b1;
                end
              end
              default: begin err_d = ErrBadHead; clr = 1'b1; end
            endcase
          end else if (ai < 5'd24) begin
            hd = 1'b1; a = {59'd0, ai};
          end else begin
            head_d = byte_i; arg_d = '0; phase_d = 2'd1;
            left_d = 4'd1 << (ai - 5'd24);
          end
        end
        // decoded head
        if (hd) begin
          if (chunk_q) begin
            if (a != '0) begin pay_d = a; phase_d = 2'd2; end
          end else begin
            case (maj)
              3'd2, 3'd3: begin
                if (a == '0) fin_d = 1'b1; else begin pay_d = a; phase_d = 2'd2; end
              end
              3'd4: begin
                if (a == '0) fin_d = 1'b1;
                else begin push = 1'b1; push_k = KindArr; push_c = a; end
              end
              3'd5: begin
                if (a == '0) fin_d = 1'b1;
                else begin push = 1'b1; push_k = KindMap; push_c = a; end
              end
              3'd6: begin push = 1'b1; push_k = KindTag; end
              3'd7: begin
                if (ai == 5'd24 && a < 64'd32) begin err_d = ErrBadHead; clr = 1'b1; end
                else fin_d = 1'b1;
              end
              default: fin_d = 1'b1;
            endcase
          end
        end
        if (push) begin
          if (sp_q >= SpW'(MaxNesting)) begin
            err_d = ErrTooDeep; clr = 1'b1;
          end else begin
            we = 1'b1; widx = IdxW'(sp_q);
            wkind = {1'b0, (ai == 5'd31), push_k}; wrem = push_c;
            sp_d = sp_q + SpW'(1);
          end
        end
      end
      CmdFinish: begin
        // one level of completion
        if (sp_q == '0) begin
          end_d = 1'b1; clr = 1'b1;
        end else if (top_kind[1:0] == KindTag) begin
          sp_d = sp_q - SpW'(1); fin_d = 1'b1;
        end else if (top_kind[1:0] == KindArr) begin
          if (!top_kind[2]) begin
            we = 1'b1; wrem = top_rem - 64'd1;
            if (top_rem == 64'd1) begin sp_d = sp_q - SpW'(1); fin_d = 1'b1; end
          end
        end else if (top_kind[2]) begin
          we = 1'b1; wkind = top_kind ^ 4'b1000;
        end else if (top_kind[3]) begin
          we = 1'b1; wkind = top_kind & 4'b0111; wrem = top_rem - 64'd1;
          if (top_rem == 64'd1) begin sp_d = sp_q - SpW'(1); fin_d = 1'b1; end
        end else begin
          we = 1'b1; wkind = top_kind | 4'b1000;
        end
      end
      default: ;
    endcase
    if (clr) begin
      phase_d = 2'd0; arg_d = '0; left_d = '0; pay_d = '0;
      chunk_d = 1'b0; cmaj_d = 3'd0; sp_d = '0; head_d = '0; fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0; arg_q <= '0; left_q <= '0; pay_q <= '0;
      chunk_q <= 1'b0; cmaj_q <= '0; head_q <= '0; sp_q <= '0;
      err_q <= ErrNone; end_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      phase_q <= phase_d; arg_q <= arg_d; left_q <= left_d; pay_q <= pay_d;
      chunk_q <= chunk_d; cmaj_q <= cmaj_d; head_q <= head_d; sp_q <= sp_d;
      err_q <= err_d; end_q <= end_d; fin_q <= fin_d;
    end
  end

  assign stat_o.need_finish = fin_q;
  assign err_o   = err_q;
  assign end_o   = end_q;
  assign depth_o = (sp_q > SpW'(127)) ? 7'd127 : 7'(sp_q);

endmodule

// ----- hw/rtl/cbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbt_ctrl
// Sequences decode and finish steps and the handshakes of both channels.
// ----------------------------------------------------------------------------
module cbt_ctrl
  import cbt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output cmd_e       cmd_o,
  input  stat_t      stat_i
);

  typedef enum logic [1:0] {
    StIdle,
    StWork,
    StHold
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] byte_q;
  logic       ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == StIdle) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_byte_o  = byte_q;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q;
    cmd_o = CmdNone;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o = CmdDecode; state_d = StWork;
        end
      end
      StWork: begin
        // walk completions up the stack, one level per cycle
        if (stat_i.need_finish) begin
          cmd_o = CmdFinish;
        end else begin
          state_d = StIdle; ovalid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0; byte_q <= '0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
      if (in_valid_i && in_ready_o) byte_q <= in_byte_i;
    end
  end

endmodule
